// ===== design/slist_pkg.sv =====
package slist_pkg;

    // List geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Transaction field widths
    localparam int KIND_W  = 2;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 4;
    localparam int FOUND_W = 5;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    // Search miss marker
    localparam logic [FOUND_W-1:0] NONE_FOUND = '1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_PLACE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

endpackage

// ===== design/slist_req_if.sv =====
interface slist_req_if
    import slist_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;

    modport source (output valid, output kind, output value, output position, input ready);
    modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

// ===== design/slist_rsp_if.sv =====
interface slist_rsp_if
    import slist_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic signed [FOUND_W-1:0] found_at;
    logic [CNT_W-1:0]          count;

    modport source (output valid, output ok, output found_at, output count, input ready);
    modport sink   (input valid, input ok, input found_at, input count, output ready);
endinterface

// ===== design/sorted_list_insert_remove_search.sv =====
// Channel  Dir  Payload                              Role
// -------  ---  -----------------------------------  --------------------------------
// req      in   kind[1:0] value[31:0] position[3:0]  insert / remove / search request
// rsp      out  ok found_at[4:0] count[4:0]          one result per request
//
// Flow: one transaction at a time; each entry visited costs a memory read
// then a compare/write step, so the single list port sets the pace. Refused
// insert/remove, tail remove and no-op read no entries and go straight to
// the result.
// Reset: rst_n clears the fill count and control, not the list contents.
// Stalls: req.ready is high only in idle; a waiting result delays only hand-off.
module sorted_list_insert_remove_search
    import slist_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    slist_req_if.sink   req,
    slist_rsp_if.source rsp
);

    state_t                    state_reg, state_next;
    logic [KIND_W-1:0]         op_reg, op_next;
    logic signed [VAL_W-1:0]   val_reg, val_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic                      ok_reg, ok_next;
    logic [FOUND_W-1:0]        found_reg, found_next;

    logic                      rsp_valid_reg, rsp_valid_next;
    logic                      rsp_ok_reg, rsp_ok_next;
    logic [FOUND_W-1:0]        rsp_found_reg, rsp_found_next;
    logic [CNT_W-1:0]          rsp_count_reg, rsp_count_next;

    // List storage: one write and one registered read per cycle
    logic signed [VAL_W-1:0]   mem [DEPTH];
    logic signed [VAL_W-1:0]   rdata_reg;
    logic [IDX_W-1:0]          rd_addr;
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic signed [VAL_W-1:0]   mem_wdata;

    // Remove position, clamped to the last held entry
    logic [CNT_W-1:0]          pos_ext;
    logic [CNT_W-1:0]          last_pos;
    logic [CNT_W-1:0]          rm_pos;

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = rsp_valid_reg;
    assign rsp.ok       = rsp_ok_reg;
    assign rsp.found_at = rsp_found_reg;
    assign rsp.count    = rsp_count_reg;

    assign pos_ext  = CNT_W'(req.position);
    assign last_pos = fill_reg - CNT_W'(1);
    assign rm_pos   = (pos_ext >= fill_reg) ? last_pos : pos_ext;

    // Read address: insert looks one below the hole, remove one above it
    always_comb
    begin
        unique case (op_reg)
            KIND_INSERT: rd_addr = IDX_W'(idx_reg - 1'b1);
            KIND_REMOVE: rd_addr = IDX_W'(idx_reg + 1'b1);
            default:     rd_addr = idx_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        fill_next      = fill_reg;
        ok_next        = ok_reg;
        found_next     = found_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_ok_next    = rsp_ok_reg;
        rsp_found_next = rsp_found_reg;
        rsp_count_next = rsp_count_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = val_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.kind;
                    val_next   = req.value;
                    ok_next    = 1'b0;
                    found_next = NONE_FOUND;
                    state_next = S_DONE;
                    unique case (req.kind)
                        KIND_INSERT:
                        begin
                            if (fill_reg == CNT_W'(DEPTH))
                            begin
                                state_next = S_DONE;
                            end
                            else if (fill_reg == '0)
                            begin
                                idx_next   = '0;
                                state_next = S_PLACE;
                            end
                            else
                            begin
                                idx_next   = fill_reg[IDX_W-1:0];
                                state_next = S_READ;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (fill_reg != '0)
                            begin
                                if (rm_pos == last_pos)
                                begin
                                    // tail entry: nothing to move
                                    fill_next = fill_reg - CNT_W'(1);
                                    ok_next   = 1'b1;
                                end
                                else
                                begin
                                    idx_next   = rm_pos[IDX_W-1:0];
                                    state_next = S_READ;
                                end
                            end
                        end
                        KIND_SEARCH:
                        begin
                            if (fill_reg != '0)
                            begin
                                idx_next   = '0;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                unique case (op_reg)
                    KIND_INSERT:
                    begin
                        if (rdata_reg >= val_reg)
                        begin
                            // move entry up into the hole
                            mem_we    = 1'b1;
                            mem_waddr = idx_reg;
                            mem_wdata = rdata_reg;
                            idx_next  = IDX_W'(idx_reg - 1'b1);
                            state_next = (idx_reg == IDX_W'(1)) ? S_PLACE : S_READ;
                        end
                        else
                        begin
                            state_next = S_PLACE;
                        end
                    end
                    KIND_REMOVE:
                    begin
                        // move entry down over the removed slot
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg;
                        mem_wdata = rdata_reg;
                        idx_next  = IDX_W'(idx_reg + 1'b1);
                        if ((CNT_W'(idx_reg) + CNT_W'(2)) >= fill_reg)
                        begin
                            fill_next  = fill_reg - CNT_W'(1);
                            ok_next    = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        if (rdata_reg == val_reg)
                        begin
                            found_next = FOUND_W'(idx_reg);
                            state_next = S_DONE;
                        end
                        else if ((CNT_W'(idx_reg) + CNT_W'(1)) == fill_reg)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next   = IDX_W'(idx_reg + 1'b1);
                            state_next = S_READ;
                        end
                    end
                endcase
            end

            S_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = val_reg;
                fill_next  = fill_reg + CNT_W'(1);
                ok_next    = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // hand off once the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_ok_next    = ok_reg;
                    rsp_found_next = found_reg;
                    rsp_count_next = fill_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        val_reg       <= val_next;
        idx_reg       <= idx_next;
        ok_reg        <= ok_next;
        found_reg     <= found_next;
        rsp_ok_reg    <= rsp_ok_next;
        rsp_found_reg <= rsp_found_next;
        rsp_count_reg <= rsp_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_READ)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== design/slist_checker.sv =====
module slist_checker
    import slist_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               rsp_ok,
    input logic [FOUND_W-1:0] rsp_found_at,
    input logic [CNT_W-1:0]   rsp_count
);

    // a pending result is not dropped
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped while stalled");

    // count stays within the list bound
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_count <= CNT_W'(DEPTH))
        else $error("rsp count exceeds depth");

    // a successful insert or remove never reports a search hit
    a_ok_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ok |-> rsp_found_at == NONE_FOUND)
        else $error("ok result carries a search position");

    // one request in flight: ready drops after a transaction
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while busy");

endmodule

bind sorted_list_insert_remove_search slist_checker u_slist_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_ok       (rsp.ok),
    .rsp_found_at (rsp.found_at),
    .rsp_count    (rsp.count)
);

// ===== dv/slist_order_checker.sv =====
`timescale 1ns / 100ps

module slist_order_checker
    import slist_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    slist_req_if req,
    slist_rsp_if rsp,
    output int   fail_count,
    output int   pending,
    output int   full_rejects,
    output int   empty_rejects
);

    typedef struct packed {
        logic               ok;
        logic [FOUND_W-1:0] found_at;
        logic [CNT_W-1:0]   count;
    } outcome_t;

    // Shadow copy of the sorted list
    logic signed [VAL_W-1:0] held [DEPTH];
    int                      held_n;
    outcome_t                owed_results [$];
    outcome_t                due;
    outcome_t                fresh;

    function automatic outcome_t list_apply(input logic [KIND_W-1:0] kind,
                                            input logic signed [VAL_W-1:0] v,
                                            input logic [POS_W-1:0] pos);
        outcome_t r;
        int       slot;
        int       hit;
        r.ok       = 1'b0;
        r.found_at = NONE_FOUND;
        case (kind)
            KIND_INSERT:
            begin
                if (held_n < DEPTH)
                begin
                    // new value lands ahead of any equal entries
                    slot = 0;
                    while (slot < held_n && held[slot] < v)
                        slot++;
                    for (int i = held_n; i > slot; i--)
                        held[i] = held[i - 1];
                    held[slot] = v;
                    held_n++;
                    r.ok = 1'b1;
                end
            end
            KIND_REMOVE:
            begin
                if (held_n > 0)
                begin
                    slot = int'(pos);
                    if (slot >= held_n)
                        slot = held_n - 1;
                    for (int i = slot; i + 1 < held_n; i++)
                        held[i] = held[i + 1];
                    held_n--;
                    r.ok = 1'b1;
                end
            end
            KIND_SEARCH:
            begin
                hit = -1;
                for (int i = 0; i < held_n && hit < 0; i++)
                    if (held[i] == v)
                        hit = i;
                if (hit >= 0)
                    r.found_at = FOUND_W'(hit);
            end
            default:
            begin
            end
        endcase
        r.count = CNT_W'(held_n);
        return r;
    endfunction

    task automatic report(input string field, input logic signed [31:0] want,
                          input logic signed [31:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_n        = 0;
            fail_count    = 0;
            full_rejects  = 0;
            empty_rejects = 0;
            owed_results.delete();
            pending       = 0;
        end
        else
        begin
            // a result never belongs to a request taken at the same edge
            if (rsp.valid && rsp.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    fail_count++;
                    $display({"%0t: result with nothing outstanding, expected none, ",
                              "got ok=%0b found_at=%0d count=%0d"},
                             $time, rsp.ok, rsp.found_at, rsp.count);
                end
                else
                begin
                    due = owed_results.pop_front();
                    if (rsp.ok !== due.ok)
                        report("ok", {31'b0, due.ok}, {31'b0, rsp.ok});
                    if (rsp.found_at !== due.found_at)
                        report("found_at", 32'($signed(due.found_at)), 32'(rsp.found_at));
                    if (rsp.count !== due.count)
                        report("count", 32'(due.count), 32'(rsp.count));
                end
            end
            if (req.valid && req.ready)
            begin
                fresh = list_apply(req.kind, req.value, req.position);
                if (req.kind == KIND_INSERT && !fresh.ok)
                    full_rejects++;
                if (req.kind == KIND_REMOVE && !fresh.ok)
                    empty_rejects++;
                owed_results.push_back(fresh);
            end
            pending = owed_results.size();
        end
    end

endmodule

// ===== dv/sorted_list_insert_remove_search_test.sv =====
`timescale 1ns / 100ps

module sorted_list_insert_remove_search_test;
    import slist_pkg::*;

    // Unused operation code; the block answers it without touching the list
    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

    localparam int RANDOM_OPS     = 1825;  // random transactions, no-ops not counted
    localparam int HOLD_AT        = 300;   // start of the long result hold-off
    localparam int RESP_HOLD      = 250;   // cycles the result side stays stalled
    localparam int DRAIN_AT       = 900;   // sender waits here until all results are in
    localparam int SETTLE         = 40;    // settling time after the last result, before the summary
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either side

    localparam logic signed [VAL_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VMIN = 32'sh8000_0000;

    logic clk;
    logic rst_n;

    slist_req_if req_ch ();
    slist_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int full_rejects;
    int empty_rejects;

    int n_insert;
    int n_remove;
    int n_search;
    int n_nop;

    bit hold_request;

    // Recently inserted values, reused so searches and duplicates hit
    logic signed [VAL_W-1:0] recent [$];

    sorted_list_insert_remove_search u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    slist_order_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .full_rejects  (full_rejects),
        .empty_rejects (empty_rejects)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Drives one request transaction; called and returns at a falling edge.
    // valid stays high on return so back-to-back transactions need no gap.
    task automatic push_op(input logic [KIND_W-1:0] kind,
                           input logic signed [VAL_W-1:0] value,
                           input logic [POS_W-1:0] position);
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= kind;
        req_ch.value    <= value;
        req_ch.position <= position;
        do @(posedge clk); while (!req_ch.ready);
        case (kind)
            KIND_INSERT:
            begin
                n_insert++;
                recent.push_back(value);
                if (recent.size() > DEPTH)
                    void'(recent.pop_front());
            end
            KIND_REMOVE:
                n_remove++;
            KIND_SEARCH:
                n_search++;
            default:
                n_nop++;
        endcase
        @(negedge clk);
    endtask

    // Mix of a small pool (duplicates, search hits), recent inserts,
    // the 32-bit extremes and fully random words.
    function automatic logic signed [VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return int'($urandom_range(0, 12)) - 6;
        if (sel < 65 && recent.size() > 0)
            return recent[$urandom_range(0, recent.size() - 1)];
        if (sel < 75)
        begin
            case ($urandom_range(0, 3))
                0: return VMAX;
                1: return VMIN;
                2: return 0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    // Low positions are common; 15 is usually past the end
    function automatic logic [POS_W-1:0] pick_position();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return POS_W'($urandom_range(0, 15));
        if (sel < 80)
            return POS_W'($urandom_range(0, 3));
        return 4'd15;
    endfunction

    // Result side: stall pattern changes at random intervals, from
    // always ready to mostly stalled. One long hold-off on request.
    initial
    begin
        int  mode;
        int  mode_left;
        bit  held_off;
        mode      = 0;
        mode_left = 0;
        held_off  = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !held_off)
            begin
                held_off = 1;
                rsp_ch.ready <= 1'b0;
                repeat (RESP_HOLD) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 1) == 0);
                    2: rsp_ch.ready <= ($urandom_range(0, 4) != 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Watchdog: ends the run if no transaction moves for too long
    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int                      done_ops;
        int                      phase_left;
        int                      insert_pct;
        int                      burst_left;
        int                      r;
        logic signed [VAL_W-1:0] v;

        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.kind     = KIND_INSERT;
        req_ch.value    = '0;
        req_ch.position = '0;
        hold_request    = 0;
        n_insert        = 0;
        n_remove        = 0;
        n_search        = 0;
        n_nop           = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty-list cases, the unused code, extremes, a duplicate,
        // remove past the end, then fill to the top and push once more.
        push_op(KIND_SEARCH, 0, 4'd0);
        push_op(KIND_REMOVE, 0, 4'd0);
        push_op(KIND_NOP, VMAX, 4'd15);
        push_op(KIND_INSERT, VMAX, 4'd0);
        push_op(KIND_INSERT, VMIN, 4'd0);
        push_op(KIND_INSERT, 0, 4'd0);
        push_op(KIND_INSERT, 0, 4'd0);
        push_op(KIND_SEARCH, 0, 4'd0);
        push_op(KIND_REMOVE, 0, 4'd15);
        push_op(KIND_REMOVE, 0, 4'd0);
        for (int i = 0; i < DEPTH - 2; i++)
        begin
            case (i % 3)
                0: v = $urandom;
                1: v = -i;
                default: v = i * 1000;
            endcase
            if (i == DEPTH - 3)
                v = VMAX;
            push_op(KIND_INSERT, v, POS_W'(i));
        end
        push_op(KIND_INSERT, 5, 4'd0);
        push_op(KIND_SEARCH, VMAX, 4'd0);

        // Random: phases that lean toward filling, draining or holding the
        // level, with the sender working in bursts.
        done_ops   = 0;
        phase_left = 0;
        insert_pct = 50;
        burst_left = $urandom_range(1, 24);
        while (done_ops < RANDOM_OPS)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(30, 120);
                case ($urandom_range(0, 2))
                    0: insert_pct = 85;
                    1: insert_pct = 50;
                    default: insert_pct = 15;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 2)
                push_op(KIND_NOP, pick_value(), pick_position());
            else
            begin
                if (r < 22)
                    push_op(KIND_SEARCH, pick_value(), pick_position());
                else if ($urandom_range(0, 99) < insert_pct)
                    push_op(KIND_INSERT, pick_value(), pick_position());
                else
                    push_op(KIND_REMOVE, pick_value(), pick_position());
                done_ops++;
                phase_left--;
                if (done_ops == HOLD_AT)
                    hold_request = 1;
                if (done_ops == DRAIN_AT)
                begin
                    // pause until every outstanding result is back
                    req_ch.valid <= 1'b0;
                    do @(negedge clk); while (pending != 0);
                end
            end
            burst_left--;
            if (burst_left <= 0)
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                if ($urandom_range(0, 5) == 0)
                    burst_left = $urandom_range(100, 200);
                else
                    burst_left = $urandom_range(1, 24);
            end
        end

        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("Sent %0d inserts, %0d removes, %0d searches, %0d unused-code transactions.",
                 n_insert, n_remove, n_search, n_nop);
        $display("Inserts refused on a full list: %0d; removes refused on an empty list: %0d.",
                 full_rejects, empty_rejects);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/slist_pkg.sv
design/slist_req_if.sv
design/slist_rsp_if.sv
design/sorted_list_insert_remove_search.sv
design/slist_checker.sv
dv/slist_order_checker.sv
dv/sorted_list_insert_remove_search_test.sv
